[hdl/ece_pkg.sv]
// Shared constants, codes and types for the easing curve evaluator.
package ece_pkg;

  // Fixed-point format of progress and eased values: one is 2^FRAC_BITS.
  localparam int FRAC_BITS = 15;
  localparam int XW        = FRAC_BITS + 1;
  localparam int MAXPOW    = 5;
  localparam int ACC_W     = MAXPOW * XW;
  localparam int MW        = (MAXPOW - 1) * XW;
  localparam int SHW       = $clog2(ACC_W);
  localparam int QW        = XW + 1;
  localparam int CW        = 3;
  localparam int IN_W      = 16;
  localparam int FUNC_W    = 4;
  localparam int OUT_W     = 16;
  localparam int RW        = (QW > OUT_W) ? QW : OUT_W + 1;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int PIPE_LAT  = 7;

  localparam logic [XW-1:0]    ONE      = XW'(1) << FRAC_BITS;
  localparam logic [XW-1:0]    HALF     = XW'(1) << (FRAC_BITS - 1);
  localparam logic [OUT_W-1:0] OUT_MAX  = '1;
  localparam logic [OUT_W-1:0] EASED_MAX = (FRAC_BITS >= OUT_W) ? OUT_MAX : OUT_W'(ONE);

  // Curve selector codes.
  localparam logic [FUNC_W-1:0] FN_LINEAR      = 4'd0;
  localparam logic [FUNC_W-1:0] FN_QUAD_IN     = 4'd1;
  localparam logic [FUNC_W-1:0] FN_QUAD_OUT    = 4'd2;
  localparam logic [FUNC_W-1:0] FN_QUAD_INOUT  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_CUBIC_IN    = 4'd4;
  localparam logic [FUNC_W-1:0] FN_CUBIC_OUT   = 4'd5;
  localparam logic [FUNC_W-1:0] FN_CUBIC_INOUT = 4'd6;
  localparam logic [FUNC_W-1:0] FN_QUART_IN    = 4'd7;
  localparam logic [FUNC_W-1:0] FN_QUART_OUT   = 4'd8;
  localparam logic [FUNC_W-1:0] FN_QUART_INOUT = 4'd9;
  localparam logic [FUNC_W-1:0] FN_QUINT_IN    = 4'd10;
  localparam logic [FUNC_W-1:0] FN_QUINT_OUT   = 4'd11;
  localparam logic [FUNC_W-1:0] FN_QUINT_INOUT = 4'd12;

  // One item as it travels down the power pipeline.
  typedef struct packed {
    logic [XW-1:0]    x;     // base of the power, t or 1-t
    logic [ACC_W-1:0] acc;   // running power of x
    logic [CW-1:0]    cnt;   // multiplications still to do
    logic [CW-1:0]    n;     // exponent, 1 for linear
    logic             fall;  // result is one minus the scaled power
    logic             coef;  // in-out curve: scale by 2^(n-1)
  } ece_item_t;

endpackage

[hdl/ece_front.sv]
// Input stage: clamps progress, decodes the curve and picks the power base.
module ece_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ece_pkg::FUNC_W-1:0]  in_func,
  input  logic [ece_pkg::IN_W-1:0]    in_progress,
  output logic                        valid,
  output ece_pkg::ece_item_t          item
);
  import ece_pkg::*;

  localparam int TW = (XW > IN_W) ? XW : IN_W;

  logic [TW-1:0]   t_wide;
  logic [XW-1:0]   t_c;
  logic [XW-1:0]   u_c;
  logic            lower;
  logic [CW-1:0]   n;
  logic            is_out;
  logic            is_inout;
  ece_item_t       item_nxt;
  ece_item_t       item_r;
  logic            valid_r;

  // Clamp progress to one and form its complement.
  always_comb begin
    t_wide = TW'(in_progress);
    t_c    = (t_wide > TW'(ONE)) ? ONE : XW'(t_wide);
    u_c    = ONE - t_c;
    lower  = (t_c < HALF);
  end

  // Exponent from the curve family.
  always_comb begin
    case (in_func)
      FN_QUAD_IN, FN_QUAD_OUT, FN_QUAD_INOUT:    n = CW'(2);
      FN_CUBIC_IN, FN_CUBIC_OUT, FN_CUBIC_INOUT: n = CW'(3);
      FN_QUART_IN, FN_QUART_OUT, FN_QUART_INOUT: n = CW'(4);
      FN_QUINT_IN, FN_QUINT_OUT, FN_QUINT_INOUT: n = CW'(5);
      default:                                   n = CW'(1);
    endcase
  end

  // Curve shape; linear, in curves and unassigned codes leave both flags low.
  always_comb begin
    is_out   = 1'b0;
    is_inout = 1'b0;
    case (in_func)
      FN_QUAD_OUT, FN_CUBIC_OUT, FN_QUART_OUT, FN_QUINT_OUT:         is_out   = 1'b1;
      FN_QUAD_INOUT, FN_CUBIC_INOUT, FN_QUART_INOUT, FN_QUINT_INOUT: is_inout = 1'b1;
      default: begin
        is_out = 1'b0;
      end
    endcase
  end

  // Build the item: falling curves take the power of 1-t.
  always_comb begin
    item_nxt.fall = is_out | (is_inout & ~lower);
    item_nxt.coef = is_inout;
    item_nxt.x    = item_nxt.fall ? u_c : t_c;
    item_nxt.acc  = ACC_W'(item_nxt.x);
    item_nxt.n    = n;
    item_nxt.cnt  = n - CW'(1);
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

[hdl/ece_mul_stage.sv]
// One pipeline stage that multiplies the running power by its base once more.
module ece_mul_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ece_pkg::ece_item_t  in_item,
  output logic                out_valid,
  output ece_pkg::ece_item_t  out_item
);
  import ece_pkg::*;

  logic [ACC_W-1:0] prod;
  ece_item_t        item_nxt;
  ece_item_t        item_r;
  logic             valid_r;

  // Multiply only while the exponent has not been reached yet.
  always_comb begin
    prod     = in_item.acc[MW-1:0] * in_item.x;
    item_nxt = in_item;
    if (in_item.cnt != '0) begin
      item_nxt.acc = prod;
      item_nxt.cnt = in_item.cnt - CW'(1);
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      item_r <= item_nxt;
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[hdl/ece_round.sv]
// Scaling, rounding and saturation of the finished power in two stages.
module ece_round (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  ece_pkg::ece_item_t         in_item,
  output logic                       out_valid,
  output logic [ece_pkg::OUT_W-1:0]  out_eased
);
  import ece_pkg::*;

  typedef struct packed {
    logic [QW-1:0] q;
    logic          half;
    logic          sticky;
    logic          fall;
  } ece_frac_t;

  logic [SHW-1:0]   nm1;
  logic [SHW-1:0]   eff;
  logic [SHW-1:0]   hidx;
  logic [ACC_W-1:0] shifted;
  logic [ACC_W-1:0] mask;
  ece_frac_t        frac_nxt;
  ece_frac_t        frac_r;
  logic             fvalid_r;
  logic [QW-1:0]    q_up;
  logic [QW-1:0]    r;
  logic [RW-1:0]    r_w;
  logic [OUT_W-1:0] eased_nxt;
  logic [OUT_W-1:0] eased_r;
  logic             ovalid_r;

  // Split coef * x^n / one^(n-1) into integer part, half bit and sticky bit.
  always_comb begin
    nm1      = SHW'(in_item.n) - SHW'(1);
    eff      = SHW'(FRAC_BITS) * nm1 - (in_item.coef ? nm1 : SHW'(0));
    hidx     = (eff == '0) ? SHW'(0) : eff - SHW'(1);
    shifted  = in_item.acc >> eff;
    mask     = (ACC_W'(1) << hidx) - ACC_W'(1);
    frac_nxt.q      = shifted[QW-1:0];
    frac_nxt.half   = (eff != '0) & in_item.acc[hidx];
    frac_nxt.sticky = |(in_item.acc & mask);
    frac_nxt.fall   = in_item.fall;
  end

  // Round to nearest, ties up, then clamp to one and to the field.
  always_comb begin
    if (frac_r.fall) begin
      q_up = frac_r.q + QW'(frac_r.half & frac_r.sticky);
      r    = (q_up >= QW'(ONE)) ? QW'(0) : QW'(ONE) - q_up;
    end else begin
      q_up = frac_r.q + QW'(frac_r.half);
      r    = (q_up > QW'(ONE)) ? QW'(ONE) : q_up;
    end
    r_w       = RW'(r);
    eased_nxt = (r_w > RW'(OUT_MAX)) ? OUT_MAX : OUT_W'(r_w);
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      frac_r <= frac_nxt;
    end
    if (fvalid_r) begin
      eased_r <= eased_nxt;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      fvalid_r <= in_valid;
      ovalid_r <= fvalid_r;
    end
  end

  assign out_valid = ovalid_r;
  assign out_eased = eased_r;

endmodule

[hdl/easing_curve_evaluator_top.sv]
// Top level of the easing curve evaluator: input decode, power pipeline, rounding.
//
// Usage: drive in_func and in_progress and raise start; a transaction is taken
// at each rising edge where start is high and busy is low. Progress is unsigned
// fixed point with one at 32768; values above one are treated as one. The curve
// selector picks linear or the in, out or in-out quadratic, cubic, quartic or
// quintic curve; unassigned codes behave as linear.
// Each transaction yields exactly one result: out_eased is shown with out_valid
// high for a single cycle, once the item has passed the seven register stages:
// the input register, four multiplier stages and two rounding stages.
// Out of reset a transaction can be taken every cycle: throughput is one per clock.
// The receiver cannot stall the block, and results are never held back.
// Reset (synchronous, rst_n low) clears every valid bit, so transactions in
// flight are dropped; busy is high during reset and low from the first cycle
// after it, and stays low while the block runs.
module easing_curve_evaluator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ece_pkg::FUNC_W-1:0]  in_func,
  input  logic [ece_pkg::IN_W-1:0]    in_progress,
  output logic                        out_valid,
  output logic [ece_pkg::OUT_W-1:0]   out_eased
);
  import ece_pkg::*;

  logic       busy_r;
  logic       accept;
  logic       v [MAXPOW];
  ece_item_t  it [MAXPOW];

  // Busy only while in reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // Clamp and decode.
  ece_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_func     (in_func),
    .in_progress (in_progress),
    .valid       (v[0]),
    .item        (it[0])
  );

  // Chain of multiplier stages raising the base to its exponent.
  for (genvar g = 0; g < MAXPOW - 1; g++) begin : g_mul
    ece_mul_stage u_mul (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[g]),
      .in_item   (it[g]),
      .out_valid (v[g+1]),
      .out_item  (it[g+1])
    );
  end

  // Rounding and output register.
  ece_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v[MAXPOW-1]),
    .in_item   (it[MAXPOW-1]),
    .out_valid (out_valid),
    .out_eased (out_eased)
  );

`ifndef NO_ASSERTIONS
  // Every accepted transaction produces its result after the pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("result missing after pipeline latency");

  // No result appears without a transaction accepted the latency before.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LAT))
    else $error("result without a matching transaction");

  // The eased value never exceeds one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_eased <= EASED_MAX)
    else $error("eased value above one");

  // Once out of reset, the block never refuses a transaction.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");
`endif

endmodule
